FILE: sv/binary_search_engine_top_defines.svh
// ----------------------------------------------------------------------------
// binary_search_engine_top_defines.svh
// Assertion macros for the binary search engine.
// ----------------------------------------------------------------------------
`ifndef BINARY_SEARCH_ENGINE_TOP_DEFINES_SVH
`define BINARY_SEARCH_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every edge outside reset.
`define BSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BSE_ASSERT(lbl, prop, msg)
`define BSE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: sv/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the binary search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int IDX_W  = 10;  // entry_index, low_index, high_index, position
  localparam int DATA_W = 32;  // data_value port
  localparam int SPAN_W = IDX_W + 2;  // signed lo/hi, hold -1 and 1024

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_req;    // write transfer accepted
    logic load;      // search transfer accepted: load range and key
    logic probe;     // issue RAM read at midpoint
    logic step;      // narrow range after a mismatch
    logic hit;       // record found result
    logic miss;      // record not-found result
    logic out_load;  // move result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;  // hi < lo
    logic match;  // probed entry equals key
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/binary_search_engine_top.sv
// ----------------------------------------------------------------------------
// binary_search_engine_top
// Write: taken in IDLE, back to back, no result.
// Search: the range and key load in IDLE; each probe is a registered RAM
//   read, then a compare; a miss ends on the empty-range check, then the
//   output loads; up to 11 probes over a full 1024-entry range.
// Reset clears the controller and output valid; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_search_engine_top_defines.svh"

// Structure
//   bse_ctrl : sequencer IDLE -> PROBE <-> COMPARE -> DONE -> IDLE; an empty range goes PROBE -> DONE.
//   bse_dp   : clamped lo/hi range, key, midpoint, store RAM, result regs.
//
// Input side
//   A transfer is taken only in IDLE. A write goes straight to the RAM and
//   leaves the block in IDLE, so writes stream at one per cycle. Writes to
//   positions at or beyond STORE_DEPTH are dropped.
//
// Search
//   Range ends beyond the store clamp to STORE_DEPTH-1. Each probe reads
//   the lower midpoint of [lo, hi]; a larger entry moves hi to mid-1, a
//   smaller one moves lo to mid+1. An empty range ends as not found with
//   position zero. The probe loop runs over the single RAM read port, and
//   no new transfer is taken until the search returns to IDLE.
//
// Output side
//   The result sits in an output register. The controller frees the input
//   side as soon as the result is loaded, so the next transfer can be taken
//   while the result waits on out_stall.

module binary_search_engine_top #(
  parameter int STORE_DEPTH = bse_pkg::STORE_DEPTH_DEF,
  parameter int VALUE_WIDTH = bse_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              opcode,
  input  wire logic        [bse_pkg::IDX_W-1:0]  entry_index,
  input  wire logic signed [bse_pkg::DATA_W-1:0] data_value,
  input  wire logic        [bse_pkg::IDX_W-1:0]  low_index,
  input  wire logic        [bse_pkg::IDX_W-1:0]  high_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   found,
  output logic             [bse_pkg::IDX_W-1:0]  position
);

  bse_pkg::dp_cmd_t  cmd;
  bse_pkg::dp_stat_t stat;

  // input transfers by kind
  logic search_xfer;
  logic write_xfer;

  assign search_xfer = in_valid && !in_stall && (opcode == bse_pkg::OP_SEARCH);
  assign write_xfer  = in_valid && !in_stall && (opcode == bse_pkg::OP_WRITE);

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bse_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .entry_index (entry_index),
    .data_value  (data_value),
    .low_index   (low_index),
    .high_index  (high_index),
    .found       (found),
    .position    (position)
  );

  // a search transfer locks the input side for the next cycle
  `BSE_ASSERT(a_search_locks, search_xfer |=> in_stall, "search did not lock input")

  // a write transfer leaves the input side open
  `BSE_ASSERT(a_write_streams, write_xfer |=> !in_stall, "write stalled input")

  // a miss always reports position zero
  `BSE_ASSERT(a_miss_pos_zero, (out_valid && !found) |-> position == '0, "miss not at zero")

  // nothing is offered on the output during reset
  `BSE_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "output valid after reset")

endmodule

`default_nettype wire

FILE: sv/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bse_dp.sv
// ----------------------------------------------------------------------------
// bse_dp
// Search datapath: range registers, midpoint, store RAM, compare, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_dp #(
  parameter int STORE_DEPTH = bse_pkg::STORE_DEPTH_DEF,
  parameter int VALUE_WIDTH = bse_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire bse_pkg::dp_cmd_t                  cmd,
  output bse_pkg::dp_stat_t                      stat,
  input  wire logic        [bse_pkg::IDX_W-1:0]  entry_index,
  input  wire logic signed [bse_pkg::DATA_W-1:0] data_value,
  input  wire logic        [bse_pkg::IDX_W-1:0]  low_index,
  input  wire logic        [bse_pkg::IDX_W-1:0]  high_index,
  output logic                                   found,
  output logic             [bse_pkg::IDX_W-1:0]  position
);

  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int MAX_IDX = STORE_DEPTH - 1;

  logic signed [bse_pkg::SPAN_W-1:0] lo;
  logic signed [bse_pkg::SPAN_W-1:0] hi;
  logic signed [VALUE_WIDTH-1:0]     key;
  logic        [bse_pkg::IDX_W-1:0]  mid;
  logic                              res_found;
  logic        [bse_pkg::IDX_W-1:0]  res_pos;

  logic        [bse_pkg::IDX_W-1:0]  lo_clamp;
  logic        [bse_pkg::IDX_W-1:0]  hi_clamp;
  logic signed [bse_pkg::SPAN_W-1:0] mid_calc;
  logic signed [bse_pkg::SPAN_W-1:0] mid_ext;
  logic signed [VALUE_WIDTH-1:0]     value_ext;
  logic        [VALUE_WIDTH-1:0]     rd_data;
  logic                              wr_en;
  logic                              greater;

  // range ends beyond the store clamp to its last entry
  always_comb begin
    lo_clamp = low_index;
    hi_clamp = high_index;
    if (32'(low_index) > MAX_IDX) begin
      lo_clamp = bse_pkg::IDX_W'(MAX_IDX);
    end
    if (32'(high_index) > MAX_IDX) begin
      hi_clamp = bse_pkg::IDX_W'(MAX_IDX);
    end
  end

  assign value_ext = VALUE_WIDTH'(data_value);
  assign wr_en     = cmd.wr_req && (32'(entry_index) < STORE_DEPTH);

  // lower midpoint; hi - lo is nonnegative whenever a probe is issued
  assign mid_calc  = lo + ((hi - lo) >>> 1);
  assign mid_ext   = $signed({2'b00, mid});

  assign stat.empty = (hi < lo);
  assign stat.match = ($signed(rd_data) == key);
  assign greater    = ($signed(rd_data) > key);

  bse_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (value_ext),
    .rd_en   (cmd.probe),
    .rd_addr (AW'(mid_calc[bse_pkg::IDX_W-1:0])),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo  <= $signed({2'b00, lo_clamp});
      hi  <= $signed({2'b00, hi_clamp});
      key <= value_ext;
    end else if (cmd.step) begin
      if (greater) begin
        hi <= mid_ext - bse_pkg::SPAN_W'(1);
      end else begin
        lo <= mid_ext + bse_pkg::SPAN_W'(1);
      end
    end
    if (cmd.probe) begin
      mid <= mid_calc[bse_pkg::IDX_W-1:0];
    end
    if (cmd.hit) begin
      res_found <= 1'b1;
      res_pos   <= mid;
    end else if (cmd.miss) begin
      res_found <= 1'b0;
      res_pos   <= '0;
    end
    if (cmd.out_load) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Search sequencer and output handshake control.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              opcode,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire bse_pkg::dp_stat_t stat,
  output bse_pkg::dp_cmd_t       cmd
);

  bse_pkg::state_t state;
  bse_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bse_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != bse_pkg::ST_IDLE);

    unique case (state)
      bse_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (opcode == bse_pkg::OP_WRITE) begin
            cmd.wr_req = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = bse_pkg::ST_PROBE;
          end
        end
      end
      bse_pkg::ST_PROBE: begin
        if (stat.empty) begin
          cmd.miss   = 1'b1;
          state_next = bse_pkg::ST_DONE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = bse_pkg::ST_COMPARE;
        end
      end
      bse_pkg::ST_COMPARE: begin
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = bse_pkg::ST_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = bse_pkg::ST_PROBE;
        end
      end
      bse_pkg::ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = bse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bse_pkg::ST_IDLE;
      end
    endcase

    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: tb/binary_search_engine_top_test.sv
// ----------------------------------------------------------------------------
// binary_search_engine_top_test
// Self-checking bench for the binary search engine. Sorted runs, stray
// out-of-order writes and searches over tracked entries are pushed through
// the valid/stall ports. Each search result is compared with a bench-side
// walk of the same midpoint probe sequence over a mirror of the store.
// ----------------------------------------------------------------------------
module binary_search_engine_top_test;
  import bse_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;  // long output back-pressure stretch
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic                     op;
    logic [IDX_W-1:0]         entry;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         lo;
    logic [IDX_W-1:0]         hi;
  } request_t;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] position;
  } answer_t;

  // Mirror of the store plus the queue of search answers still owed.
  class search_scoreboard;
    logic signed [DATA_W-1:0] entries [DEPTH];
    answer_t expected [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Lower-midpoint binary search over the mirrored entries.
    function answer_t search_answer(logic signed [DATA_W-1:0] key,
                                    logic [IDX_W-1:0] lo_i, logic [IDX_W-1:0] hi_i);
      answer_t a;
      int lo, hi, mid;
      a.found = 1'b0;
      a.position = '0;
      lo = lo_i;
      hi = hi_i;
      while (hi >= lo) begin
        mid = lo + (hi - lo) / 2;
        if (entries[mid] == key) begin
          a.found = 1'b1;
          a.position = IDX_W'(mid);
          break;
        end
        if (entries[mid] > key) hi = mid - 1;
        else lo = mid + 1;
      end
      return a;
    endfunction

    function void note_input(request_t r);
      if (r.op == OP_WRITE) entries[r.entry] = r.value;
      else expected.push_back(search_answer(r.value, r.lo, r.hi));
    endfunction

    function void check_result(logic f, logic [IDX_W-1:0] p);
      answer_t exp;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result: found %0b position %0d", $time, f, p);
        errors++;
        return;
      end
      exp = expected.pop_front();
      if (f !== exp.found) begin
        $display("%0t: found mismatch: expected %0b actual %0b", $time, exp.found, f);
        errors++;
      end
      if (p !== exp.position) begin
        $display("%0t: position mismatch: expected %0d actual %0d",
                 $time, exp.position, p);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = OP_WRITE;
  logic [IDX_W-1:0]         entry_index = '0;
  logic signed [DATA_W-1:0] data_value = '0;
  logic [IDX_W-1:0]         low_index = '0;
  logic [IDX_W-1:0]         high_index = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [IDX_W-1:0]         position;

  search_scoreboard sb = new();

  // Stimulus-side view of the store: what has been issued, used to steer
  // every search away from entries that were never written.
  logic signed [DATA_W-1:0] shadow [DEPTH];
  bit                       shadow_valid [DEPTH];

  int  in_idle_pct = 0;
  int  stall_pct = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  hold_go = 1'b0;
  logic long_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_search_engine_top dut (
    .clk, .rst, .in_valid, .in_stall, .opcode, .entry_index, .data_value,
    .low_index, .high_index, .out_valid, .out_stall, .found, .position
  );

  // --------------------------------------------------------------------------
  // Input side: optional idle cycles, then hold the transfer until taken.
  // --------------------------------------------------------------------------
  task automatic drive_item(input request_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= r.op;
    entry_index <= r.entry;
    data_value  <= r.value;
    low_index   <= r.lo;
    high_index  <= r.hi;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(r);
    items_sent++;
  endtask

  // Range fields are don't-care on a write; randomize them anyway.
  task automatic write_entry(input int idx, input logic signed [DATA_W-1:0] v);
    request_t r;
    shadow[idx] = v;
    shadow_valid[idx] = 1'b1;
    r.op    = OP_WRITE;
    r.entry = IDX_W'(idx);
    r.value = v;
    r.lo    = IDX_W'($urandom);
    r.hi    = IDX_W'($urandom);
    drive_item(r);
  endtask

  // Value for a gap entry: between its nearest written neighbors, so a
  // sorted region stays sorted.
  function automatic logic signed [DATA_W-1:0] fill_value(input int idx);
    longint lwb, upb, span;
    int k;
    lwb = VAL_MIN;
    upb = VAL_MAX;
    for (k = idx - 1; k >= 0; k--) begin
      if (shadow_valid[k]) begin
        lwb = shadow[k];
        break;
      end
    end
    for (k = idx + 1; k < DEPTH; k++) begin
      if (shadow_valid[k]) begin
        upb = shadow[k];
        break;
      end
    end
    if (lwb > upb) return $urandom;
    span = upb - lwb + 1;
    return DATA_W'(lwb + longint'({$urandom, $urandom} % span));
  endfunction

  // Walks the probe path first; any entry it would read unwritten gets a
  // write ahead of the search transfer.
  task automatic search_item(input logic signed [DATA_W-1:0] key,
                             input int lo, input int hi);
    request_t r;
    int a, b, mid;
    a = lo;
    b = hi;
    while (b >= a) begin
      mid = a + (b - a) / 2;
      if (!shadow_valid[mid]) write_entry(mid, fill_value(mid));
      if (shadow[mid] == key) break;
      if (shadow[mid] > key) b = mid - 1;
      else a = mid + 1;
    end
    r.op    = OP_SEARCH;
    r.entry = IDX_W'($urandom);
    r.value = key;
    r.lo    = IDX_W'(lo);
    r.hi    = IDX_W'(hi);
    drive_item(r);
  endtask

  // Mostly keys that are present, then near misses, extremes, noise.
  function automatic logic signed [DATA_W-1:0] pick_key(input int lo, input int hi);
    int idx, sel;
    sel = $urandom_range(99);
    idx = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(DEPTH - 1);
    if (sel < 55 && shadow_valid[idx]) return shadow[idx];
    if (sel < 70 && shadow_valid[idx]) return shadow[idx] + ($urandom_range(1) ? 1 : -1);
    if (sel < 80) return $urandom_range(1) ? VAL_MIN : VAL_MAX;
    return $urandom;
  endfunction

  // Ascending run with repeats, small and large steps, saturating at max.
  task automatic write_sorted_run(input int base, input int len);
    longint v;
    int i;
    case ($urandom_range(3))
      0: v = longint'(VAL_MIN) + longint'($urandom_range(15));
      1: v = longint'($signed($urandom));
      default: v = longint'($urandom_range(2000)) - 1000;
    endcase
    for (i = 0; i < len; i++) begin
      write_entry(base + i, DATA_W'(v));
      case ($urandom_range(7))
        0: ;
        1: v += longint'($urandom_range(1 << 28));
        default: v += longint'($urandom_range(8, 1));
      endcase
      if (v > longint'(VAL_MAX)) v = VAL_MAX;
    end
  endtask

  task automatic search_run(input int base, input int len, input int count);
    int lo, hi;
    repeat (count) begin
      lo = base;
      hi = base + len - 1;
      if ($urandom_range(2) == 0) begin
        lo = $urandom_range(base + len - 1, base);
        hi = $urandom_range(base + len - 1, lo);
      end
      search_item(pick_key(lo, hi), lo, hi);
    end
  endtask

  // Full range, inverted range, single entry or any ordered range.
  task automatic loose_search();
    int lo, hi;
    case ($urandom_range(3))
      0: begin
        lo = 0;
        hi = DEPTH - 1;
      end
      1: begin
        lo = $urandom_range(DEPTH - 1, 1);
        hi = $urandom_range(lo - 1);
      end
      2: begin
        lo = $urandom_range(DEPTH - 1);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(DEPTH - 1);
        hi = $urandom_range(DEPTH - 1, lo);
      end
    endcase
    search_item(pick_key(lo, hi), lo, hi);
  endtask

  // Random values at consecutive positions: leaves the store out of order.
  task automatic stray_writes();
    int base, n, i;
    base = $urandom_range(DEPTH - 1);
    n = $urandom_range(4, 1);
    if (base + n > DEPTH) n = DEPTH - base;
    for (i = 0; i < n; i++) write_entry(base + i, $urandom);
    if ($urandom_range(1)) search_run(base, n, 1);
  endtask

  task automatic random_traffic(input int upto);
    int base, len, pick;
    while (items_sent < upto) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        base = $urandom_range(DEPTH - 1);
        len = ($urandom_range(15) == 0) ? $urandom_range(96, 1) : $urandom_range(16, 1);
        if (base + len > DEPTH) len = DEPTH - base;
        write_sorted_run(base, len);
        search_run(base, len, $urandom_range(6, 1));
      end else if (pick < 85) begin
        loose_search();
      end else begin
        stray_writes();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: check each transfer, then pick next cycle's stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall == 1'b0) sb.check_result(found, position);
      out_stall <= long_hold || ($urandom_range(99) < stall_pct);
    end
  end

  // One long stall so the engine finishes a search, parks the result and
  // then holds off further input.
  initial begin : hold_off
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme values at both ends of the store.
    write_entry(0, VAL_MIN);
    write_entry(DEPTH - 1, VAL_MAX);
    search_item(VAL_MAX, 0, DEPTH - 1);
    search_item(VAL_MIN, 0, 0);
    search_item(VAL_MIN, DEPTH - 1, DEPTH - 1);
    // inverted ranges end as not found without a probe
    search_item(VAL_MAX, DEPTH - 1, 0);
    search_item(VAL_MIN, 1, 0);
    // descending entries: the probe sequence runs regardless and misses
    write_entry(5, 30);
    write_entry(6, 20);
    write_entry(7, 10);
    search_item(10, 5, 7);

    // Random phases: free-running, sparse input, heavy stall, long hold, mixed.
    random_traffic(300);
    in_idle_pct = 88;
    random_traffic(560);
    in_idle_pct = 0;
    stall_pct = 88;
    random_traffic(820);
    stall_pct = 0;
    hold_go = 1'b1;
    random_traffic(880);
    in_idle_pct = 27;
    stall_pct = 27;
    random_traffic(1150);

    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
